// ----- rtl/serial_camera_yuv_to_rgb565_assert.svh -----
// ----------------------------------------------------------------------------
// serial camera yuv to rgb565 - assertion macros
// implication checks on the rising clock edge, off while reset is low
// ----------------------------------------------------------------------------
`ifndef SERIAL_CAMERA_YUV_TO_RGB565_ASSERT_SVH
`define SERIAL_CAMERA_YUV_TO_RGB565_ASSERT_SVH

// same-cycle implication
`define SCYR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCYR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/scyr_pkg.sv -----
// ----------------------------------------------------------------------------
// scyr_pkg
// frame geometry, phase codes, sync settling and yuv to rgb565 color math
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scyr_pkg;

  localparam int FRAME_WIDTH  = 96;
  localparam int FRAME_HEIGHT = 72;
  localparam int GROUP_TOTAL  = (FRAME_WIDTH * FRAME_HEIGHT) / 2;
  localparam int GRP_W        = $clog2(GROUP_TOTAL + 1);

  localparam logic [7:0] ONES_LEN_RST  = 8'd100;
  localparam logic [7:0] ZEROS_LEN_RST = 8'd65;
  localparam logic [7:0] SKIP_LEN_RST  = 8'd16;

  localparam logic [1:0] REG_ONES  = 2'd0;
  localparam logic [1:0] REG_ZEROS = 2'd1;
  localparam logic [1:0] REG_SKIP  = 2'd2;

  localparam logic [1:0] BYTE_CA = 2'd0;
  localparam logic [1:0] BYTE_Y0 = 2'd1;
  localparam logic [1:0] BYTE_CB = 2'd2;
  localparam logic [1:0] BYTE_Y1 = 2'd3;

  typedef logic [GRP_W-1:0] grp_cnt_t;

  typedef enum logic [3:0] {
    PH_ONES  = 4'b0001,
    PH_ZEROS = 4'b0010,
    PH_SKIP  = 4'b0100,
    PH_DATA  = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] run;
    logic       enter_data;
  } settle_t;

  // moves through every phase whose length is already reached
  function automatic settle_t settle(input phase_t ph, input logic [7:0] run,
                                     input logic [7:0] ones_len,
                                     input logic [7:0] zeros_len,
                                     input logic [7:0] skip_len);
    settle_t s;
    s.phase      = ph;
    s.run        = run;
    s.enter_data = 1'b0;
    if (s.phase == PH_ONES && s.run >= ones_len) begin
      s.phase = PH_ZEROS;
      s.run   = '0;
    end
    if (s.phase == PH_ZEROS && s.run >= zeros_len) begin
      s.phase = PH_SKIP;
      s.run   = '0;
    end
    if (s.phase == PH_SKIP && s.run >= skip_len) begin
      s.phase      = PH_DATA;
      s.run        = '0;
      s.enter_data = 1'b1;
    end
    return s;
  endfunction

  // q8 coefficients: 251, 136, 49
  function automatic logic [15:0] make_pixel(input logic [7:0] luma,
                                             input logic [7:0] ca,
                                             input logic [7:0] cb);
    logic signed [9:0]  y;
    logic signed [9:0]  a;
    logic signed [9:0]  b;
    logic signed [9:0]  r;
    logic signed [9:0]  bl;
    logic signed [18:0] s;
    logic [7:0]         r8;
    logic [7:0]         g8;
    logic [7:0]         b8;
    y  = $signed({2'b00, luma});
    a  = $signed({2'b00, ca}) - 10'sd128;
    b  = $signed({2'b00, cb}) - 10'sd128;
    r  = y + b;
    bl = y + a;
    s  = 19'sd251 * 19'(y) - 19'sd136 * 19'(b) - 19'sd49 * 19'(a);
    if (r < 0)             r8 = 8'd0;
    else if (r > 10'sd255) r8 = 8'd255;
    else                   r8 = r[7:0];
    if (bl < 0)             b8 = 8'd0;
    else if (bl > 10'sd255) b8 = 8'd255;
    else                    b8 = bl[7:0];
    if (s < 0)               g8 = 8'd0;
    else if (s[18:16] != '0) g8 = 8'd255;
    else                     g8 = s[15:8];
    return {r8[7:3], g8[7:2], b8[7:3]};
  endfunction

endpackage

// ----- rtl/serial_camera_yuv_to_rgb565.sv -----
// ----------------------------------------------------------------------------
// serial_camera_yuv_to_rgb565
// serial camera bit receiver: sync hunt, header skip, yuv422 to rgb565 pixels
// ----------------------------------------------------------------------------
// pair path: the group-ending item is written into the pair register; its first
//   pixel moves to the output register once that is free, the second follows
// throughput: one data bit per cycle; in_tready drops only when a group would
//   end while the previous pixel pair is still waiting in the pair register
// reset: rst_n low at a clock edge sets the hunt for the ones run, clears the
//   counters and pending pixels, and loads the registers with 100, 65 and 16
`timescale 1ns / 1ps
`include "serial_camera_yuv_to_rgb565_assert.svh"

module serial_camera_yuv_to_rgb565 (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [0] data_bit, [7:1] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [15:0] pixel
  output logic        out_tlast,    // second_of_pair
  output logic        out_tuser,    // [0] frame_end
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic [7:0] ones_len_r;
  logic [7:0] zeros_len_r;
  logic [7:0] skip_len_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  // receiver state
  scyr_pkg::phase_t   phase_r, phase_nxt;
  logic [7:0]         run_r, run_nxt;
  logic [2:0]         bitpos_r, bitpos_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [1:0]         big_r, big_nxt;
  scyr_pkg::grp_cnt_t gcnt_r, gcnt_nxt;
  logic [7:0]         held_ca_r, held_y0_r, held_cb_r;
  logic               held_ca_we, held_y0_we, held_cb_we;
  logic [7:0]         byte_v;

  // pair register
  logic               grp_valid_r, grp_valid_nxt;
  logic               grp_sel_r, grp_sel_nxt;
  logic               grp_end_r;
  logic [7:0]         grp_ca_r, grp_y0_r, grp_cb_r, grp_y1_r;
  logic               grp_load;
  logic               frame_done;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_pixel_r;
  logic               out_last_r;
  logic               out_end_r;
  logic               out_load;

  scyr_pkg::settle_t  pre, post;
  logic               in_fire;
  logic               ends_group;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (cfg_idx)
      scyr_pkg::REG_ONES:  cfg_prdata = {24'd0, ones_len_r};
      scyr_pkg::REG_ZEROS: cfg_prdata = {24'd0, zeros_len_r};
      scyr_pkg::REG_SKIP:  cfg_prdata = {24'd0, skip_len_r};
      default:             cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ones_len_r  <= scyr_pkg::ONES_LEN_RST;
      zeros_len_r <= scyr_pkg::ZEROS_LEN_RST;
      skip_len_r  <= scyr_pkg::SKIP_LEN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        scyr_pkg::REG_ONES:  ones_len_r  <= cfg_pwdata[7:0];
        scyr_pkg::REG_ZEROS: zeros_len_r <= cfg_pwdata[7:0];
        scyr_pkg::REG_SKIP:  skip_len_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // settle against the current lengths before the bit is taken
  assign pre = scyr_pkg::settle(phase_r, run_r, ones_len_r, zeros_len_r, skip_len_r);

  assign ends_group = (pre.phase == scyr_pkg::PH_DATA) && !pre.enter_data &&
                      (bitpos_r == 3'd7) && (big_r == scyr_pkg::BYTE_Y1);
  assign in_tready  = !(ends_group && grp_valid_r);
  assign in_fire    = in_tvalid & in_tready;
  assign byte_v     = {shift_r[6:0], in_tdata[0]};

  always_comb begin
    phase_nxt  = pre.phase;
    run_nxt    = pre.run;
    bitpos_nxt = bitpos_r;
    shift_nxt  = shift_r;
    big_nxt    = big_r;
    gcnt_nxt   = gcnt_r;
    held_ca_we = 1'b0;
    held_y0_we = 1'b0;
    held_cb_we = 1'b0;
    grp_load   = 1'b0;
    frame_done = 1'b0;
    if (pre.enter_data) begin
      bitpos_nxt = '0;
      shift_nxt  = '0;
      big_nxt    = scyr_pkg::BYTE_CA;
      gcnt_nxt   = '0;
    end
    case (pre.phase)
      scyr_pkg::PH_ONES:  run_nxt = in_tdata[0] ? pre.run + 8'd1 : 8'd0;
      scyr_pkg::PH_ZEROS: run_nxt = in_tdata[0] ? 8'd0 : pre.run + 8'd1;
      scyr_pkg::PH_SKIP:  run_nxt = pre.run + 8'd1;
      scyr_pkg::PH_DATA: begin
        shift_nxt  = {shift_nxt[6:0], in_tdata[0]};
        bitpos_nxt = bitpos_nxt + 3'd1;
        if (bitpos_nxt == 3'd0) begin
          shift_nxt = '0;
          case (big_nxt)
            scyr_pkg::BYTE_CA: held_ca_we = 1'b1;
            scyr_pkg::BYTE_Y0: held_y0_we = 1'b1;
            scyr_pkg::BYTE_CB: held_cb_we = 1'b1;
            default: begin
              grp_load   = 1'b1;
              gcnt_nxt   = gcnt_r + 1'b1;
              frame_done = (gcnt_nxt == scyr_pkg::grp_cnt_t'(scyr_pkg::GROUP_TOTAL));
            end
          endcase
          big_nxt = big_nxt + 2'd1;
        end
        if (frame_done) begin
          phase_nxt  = scyr_pkg::PH_ONES;
          run_nxt    = '0;
          bitpos_nxt = '0;
          gcnt_nxt   = '0;
        end
      end
      default: ;
    endcase
    // a sync bit settles again so a reached length is left at once;
    // after a frame the hunt settles only when the next bit comes
    post = scyr_pkg::settle(phase_nxt, run_nxt, ones_len_r, zeros_len_r, skip_len_r);
    if (pre.phase != scyr_pkg::PH_DATA) begin
      phase_nxt = post.phase;
      run_nxt   = post.run;
      if (post.enter_data) begin
        bitpos_nxt = '0;
        shift_nxt  = '0;
        big_nxt    = scyr_pkg::BYTE_CA;
        gcnt_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= scyr_pkg::PH_ONES;
      run_r    <= '0;
      bitpos_r <= '0;
      shift_r  <= '0;
      big_r    <= scyr_pkg::BYTE_CA;
      gcnt_r   <= '0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      run_r    <= run_nxt;
      bitpos_r <= bitpos_nxt;
      shift_r  <= shift_nxt;
      big_r    <= big_nxt;
      gcnt_r   <= gcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && held_ca_we) held_ca_r <= byte_v;
    if (in_fire && held_y0_we) held_y0_r <= byte_v;
    if (in_fire && held_cb_we) held_cb_r <= byte_v;
  end

  // pair register feeds two pixels, luma0 first
  assign out_load = grp_valid_r && (!out_valid_r || out_tready);

  always_comb begin
    grp_valid_nxt = grp_valid_r;
    grp_sel_nxt   = grp_sel_r;
    if (out_load) begin
      if (grp_sel_r) grp_valid_nxt = 1'b0;
      else           grp_sel_nxt   = 1'b1;
    end
    if (in_fire && grp_load) begin
      grp_valid_nxt = 1'b1;
      grp_sel_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      grp_sel_r   <= 1'b0;
    end else begin
      grp_valid_r <= grp_valid_nxt;
      grp_sel_r   <= grp_sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && grp_load) begin
      grp_ca_r  <= held_ca_r;
      grp_y0_r  <= held_y0_r;
      grp_cb_r  <= held_cb_r;
      grp_y1_r  <= byte_v;
      grp_end_r <= frame_done;
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel_r <= scyr_pkg::make_pixel(grp_sel_r ? grp_y1_r : grp_y0_r,
                                          grp_ca_r, grp_cb_r);
      out_last_r  <= grp_sel_r;
      out_end_r   <= grp_sel_r & grp_end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_end_r;

  `SCYR_ASSERT_IMP(a_pair_free, clk, rst_n, in_fire && grp_load, !grp_valid_r, "pair overwritten")
  `SCYR_ASSERT_NXT(a_pair_drain, clk, rst_n, out_load && grp_sel_r, !grp_valid_r, "pair not drained")
  `SCYR_ASSERT_IMP(a_end_last, clk, rst_n, out_valid_r && out_end_r, out_last_r, "frame end on luma0")
  `SCYR_ASSERT_IMP(a_gcnt_range, clk, rst_n, 1'b1, gcnt_r < scyr_pkg::grp_cnt_t'(scyr_pkg::GROUP_TOTAL), "group count overrun")

endmodule
